// ===== hw/rtl/swipe_gesture_classifier_unit_assert.svh =====
// Assertion macros shared by the swipe classifier RTL.
// No dependencies; included by modules that carry checks.
`ifndef SWIPE_GESTURE_CLASSIFIER_UNIT_ASSERT_SVH
`define SWIPE_GESTURE_CLASSIFIER_UNIT_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define SGC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgc assertion failed (same cycle)");

// antecedent holds -> consequent holds in the next cycle
`define SGC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgc assertion failed (next cycle)");

`endif

// ===== hw/rtl/sgc_pkg.sv =====
// Shared types and constants for the swipe gesture classifier.
// No dependencies.
package sgc_pkg;

   localparam int COUNT_W = 8;
   localparam int THR_W   = 8;
   localparam int SENS_W  = 9;
   localparam int DIR_W   = 9;   // signed, right-left or up-down
   localparam int DIFF_W  = 11;  // signed entry minus current, with sensitivity headroom
   localparam int GEST_W  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic [THR_W-1:0]  THR_RESET  = 8'd30;
   localparam logic [SENS_W-1:0] SENS_RESET = 9'd80;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWIPE_SENSITIVITY  = 1'd1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [GEST_W-1:0] GEST_NONE  = 3'd0;
   localparam logic [GEST_W-1:0] GEST_UP    = 3'd1;
   localparam logic [GEST_W-1:0] GEST_DOWN  = 3'd2;
   localparam logic [GEST_W-1:0] GEST_LEFT  = 3'd3;
   localparam logic [GEST_W-1:0] GEST_RIGHT = 3'd4;

   typedef struct packed {
      logic               operation;
      logic [COUNT_W-1:0] count_up;
      logic [COUNT_W-1:0] count_down;
      logic [COUNT_W-1:0] count_left;
      logic [COUNT_W-1:0] count_right;
   } req_item_type;

   typedef struct packed {
      logic [GEST_W-1:0] gesture;
      logic              object_absent;
   } rsp_item_type;

   typedef struct packed {
      logic [THR_W-1:0]  presence_threshold;
      logic [SENS_W-1:0] swipe_sensitivity;
   } cfg_type;

endpackage

// ===== hw/rtl/sgc_core.sv =====
// Classifier state and per-item update logic.
// Depends on sgc_pkg and swipe_gesture_classifier_unit_assert.svh.
`include "swipe_gesture_classifier_unit_assert.svh"

module sgc_core
   import sgc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   logic signed [DIR_W-1:0] cur_x_ff, cur_x_in;
   logic signed [DIR_W-1:0] cur_y_ff, cur_y_in;
   logic signed [DIR_W-1:0] ent_x_ff, ent_x_in;
   logic signed [DIR_W-1:0] ent_y_ff, ent_y_in;
   logic                    absent_ff, absent_in;
   logic [GEST_W-1:0]       gesture_ff, gesture_in;

   logic                     no_object;
   logic signed [DIR_W-1:0]  samp_x, samp_y;
   logic signed [DIFF_W-1:0] dx, dy, sens_pos, sens_neg;
   logic [GEST_W-1:0]        swipe_gest;

   assign no_object = (item.count_up    < cfg.presence_threshold) &&
                      (item.count_down  < cfg.presence_threshold) &&
                      (item.count_left  < cfg.presence_threshold) &&
                      (item.count_right < cfg.presence_threshold);

   assign samp_x = $signed({1'b0, item.count_right}) - $signed({1'b0, item.count_left});
   assign samp_y = $signed({1'b0, item.count_up})    - $signed({1'b0, item.count_down});

   assign dx = DIFF_W'(ent_x_ff) - DIFF_W'(cur_x_ff);
   assign dy = DIFF_W'(ent_y_ff) - DIFF_W'(cur_y_ff);
   assign sens_pos = $signed({2'b00, cfg.swipe_sensitivity});
   assign sens_neg = -sens_pos;

   // vertical beats horizontal; keep old gesture when nothing exceeds
   always_comb begin
      if (dy > sens_pos) begin
         swipe_gest = GEST_UP;
      end else if (dy < sens_neg) begin
         swipe_gest = GEST_DOWN;
      end else if (dx > sens_pos) begin
         swipe_gest = GEST_RIGHT;
      end else if (dx < sens_neg) begin
         swipe_gest = GEST_LEFT;
      end else begin
         swipe_gest = gesture_ff;
      end
   end

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      ent_x_in   = ent_x_ff;
      ent_y_in   = ent_y_ff;
      absent_in  = absent_ff;
      gesture_in = gesture_ff;
      result.gesture       = gesture_ff;
      result.object_absent = absent_ff;
      case (item.operation)
         OP_READ: begin
            gesture_in = GEST_NONE;
         end
         OP_SAMPLE: begin
            if (no_object) begin
               absent_in = 1'b1;
               // zero entry direction means nothing recorded
               if ((ent_x_ff != '0) || (ent_y_ff != '0)) begin
                  gesture_in = swipe_gest;
                  cur_x_in   = '0;
                  cur_y_in   = '0;
                  ent_x_in   = '0;
                  ent_y_in   = '0;
               end
            end else begin
               cur_x_in = samp_x;
               cur_y_in = samp_y;
               if (absent_ff) begin
                  absent_in = 1'b0;
                  ent_x_in  = samp_x;
                  ent_y_in  = samp_y;
               end
            end
            result.gesture       = gesture_in;
            result.object_absent = absent_in;
         end
         default: begin
            gesture_in = gesture_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         ent_x_ff   <= '0;
         ent_y_ff   <= '0;
         absent_ff  <= 1'b0;
         gesture_ff <= GEST_NONE;
      end else if (step_en) begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         ent_x_ff   <= ent_x_in;
         ent_y_ff   <= ent_y_in;
         absent_ff  <= absent_in;
         gesture_ff <= gesture_in;
      end
   end

   `SGC_ASSERT_NEXT(a_read_clears, clock, reset, step_en && (item.operation == OP_READ), gesture_ff == GEST_NONE)
   `SGC_ASSERT_NEXT(a_absent_sets, clock, reset, step_en && (item.operation == OP_SAMPLE) && no_object, absent_ff && (ent_x_ff == '0) && (ent_y_ff == '0))
   `SGC_ASSERT_SAME(a_gesture_code, clock, reset, 1'b1, gesture_ff <= GEST_RIGHT)

endmodule

// ===== hw/rtl/swipe_gesture_classifier_unit.sv =====
// Top level of the swipe gesture classifier: handshake stages and config registers.
// Depends on sgc_pkg, sgc_core and swipe_gesture_classifier_unit_assert.svh.
//
//   channel | direction | ports                         | moves
//   req     | in        | req_valid/req_stall/req_item  | one sample or read item
//   rsp     | out       | rsp_valid/rsp_stall/rsp_item  | one result item per req item
//   csr     | in        | csr_we/csr_index/csr_wdata    | register write, no handshake
//
// One item per cycle sustained while rsp_stall is low; rsp_valid rises once an item
// has passed the input register and then the result register. The state update is
// a single combinational pass.
// Reset is synchronous: clears both stages, state and config to defaults.
// A stalled result holds its register; the input stage can still take one item behind it.
`include "swipe_gesture_classifier_unit_assert.svh"

module swipe_gesture_classifier_unit
   import sgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff;
   req_item_type in_item_ff;
   logic         in_valid_ff;
   rsp_item_type out_item_ff;
   logic         out_valid_ff;
   rsp_item_type core_result;
   logic         advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.presence_threshold <= THR_RESET;
         cfg_ff.swipe_sensitivity  <= SENS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PRESENCE_THRESHOLD: cfg_ff.presence_threshold <= csr_wdata[THR_W-1:0];
            CSR_SWIPE_SENSITIVITY:  cfg_ff.swipe_sensitivity  <= csr_wdata[SENS_W-1:0];
            default:                cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   sgc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step_en(advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   `SGC_ASSERT_NEXT(a_advance_out, clock, reset, advance,
                    out_valid_ff && (out_item_ff == $past(core_result)))
   `SGC_ASSERT_NEXT(a_hold_in, clock, reset, in_valid_ff && !advance,
                    in_valid_ff && $stable(in_item_ff))
   `SGC_ASSERT_SAME(a_rise_cause, clock, reset, $rose(out_valid_ff), $past(advance))

endmodule
